FILE: rtl/core/wdt_pkg.sv
package wdt_pkg;

    // Item kinds carried on the mode field.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Write aliases selected by address bits 13:12.
    localparam logic [1:0] ALIAS_PLAIN = 2'd0;
    localparam logic [1:0] ALIAS_XOR   = 2'd1;
    localparam logic [1:0] ALIAS_SET   = 2'd2;
    localparam logic [1:0] ALIAS_CLR   = 2'd3;

    // Access widths.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // Reset cause codes.
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_EXPIRY = 2'd1;
    localparam logic [1:0] CAUSE_FORCED = 2'd2;

    // Word-aligned register offsets.
    localparam logic [11:0] OFF_CTRL   = 12'h000;
    localparam logic [11:0] OFF_LOAD   = 12'h004;
    localparam logic [11:0] OFF_REASON = 12'h008;
    localparam logic [11:0] OFF_TICK   = 12'h02c;

    // Word index of the first scratch register.
    localparam logic [9:0] SCRATCH_BASE_WORD = 10'd3;

    localparam logic [23:0] COUNT_MASK    = 24'hffffff;
    localparam logic [9:0]  TICK_RESET    = 10'h200;
    localparam logic [2:0]  PAUSE_RESET   = 3'b111;
    localparam int          TICK_EN_BIT   = 9;
    localparam int          CTRL_TRIG_BIT = 31;
    localparam int          CTRL_EN_BIT   = 30;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] address;
        logic [31:0] write_data;
        logic [1:0]  size_code;
    } wdt_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        reset_request;
        logic [1:0]  reset_cause;
    } wdt_result_t;

    function automatic logic [31:0] alias_apply(
        input logic [31:0] old_value,
        input logic [31:0] new_value,
        input logic [1:0]  kind
    );
        logic [31:0] res;
        case (kind)
            ALIAS_XOR: res = old_value ^ new_value;
            ALIAS_SET: res = old_value | new_value;
            ALIAS_CLR: res = old_value & ~new_value;
            default:   res = new_value;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/wdt_exec.sv
module wdt_exec
    import wdt_pkg::*;
#(
    parameter int SCRATCH_WORDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  wdt_item_t   item,
    output wdt_result_t result
);

    localparam int SIDX_W = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;
    localparam logic [9:0] SCR_LIMIT = 10'(SCRATCH_WORDS);

    logic        enable_reg, enable_next;
    logic [2:0]  pause_reg, pause_next;
    logic [23:0] load_reg, load_next;
    logic [23:0] count_reg, count_next;
    logic        active_reg, active_next;
    logic [1:0]  cause_reg, cause_next;
    logic [9:0]  tick_reg, tick_next;
    logic [31:0] scratch_reg [SCRATCH_WORDS];

    logic [1:0]        kind;
    logic [11:0]       offset;
    logic [11:0]       word;
    logic [9:0]        word_idx;
    logic [9:0]        slot_full;
    logic              slot_hit;
    logic [SIDX_W-1:0] slot_idx;
    logic              tick_runs;
    logic [31:0]       ctrl_value;
    logic [31:0]       read_word;
    logic [31:0]       read_shifted;
    logic [31:0]       wr_value;
    logic [31:0]       ctrl_new;
    logic              scr_we;
    logic [31:0]       scr_wdata;

    assign kind      = item.address[13:12];
    assign offset    = item.address[11:0];
    assign word      = {offset[11:2], 2'b00};
    assign word_idx  = offset[11:2];
    assign slot_full = word_idx - SCRATCH_BASE_WORD;
    assign slot_hit  = (word_idx >= SCRATCH_BASE_WORD) && (slot_full < SCR_LIMIT);
    assign slot_idx  = slot_full[SIDX_W-1:0];

    assign tick_runs  = tick_reg[TICK_EN_BIT] && (tick_reg[8:0] != 9'd0);
    assign ctrl_value = {1'b0, enable_reg, 3'b000, pause_reg, count_reg};
    assign ctrl_new   = alias_apply(ctrl_value, wr_value, kind);

    // Narrow writes copy the low lanes across the whole word.
    always_comb
    begin
        case (item.size_code)
            SIZE_BYTE: wr_value = {4{item.write_data[7:0]}};
            SIZE_HALF: wr_value = {2{item.write_data[15:0]}};
            default:   wr_value = item.write_data;
        endcase
    end

    always_comb
    begin
        read_word = 32'd0;
        if (word == OFF_CTRL)
        begin
            read_word = ctrl_value;
        end
        else if (word == OFF_REASON)
        begin
            read_word = {30'd0, cause_reg};
        end
        else if (word == OFF_TICK)
        begin
            read_word = {22'd0, tick_reg};
            if (tick_runs)
            begin
                read_word = {12'd0, tick_reg[8:0], 1'b1, tick_reg};
            end
        end
        else if (slot_hit)
        begin
            read_word = scratch_reg[slot_idx];
        end
    end

    assign read_shifted = read_word >> {offset[1:0], 3'b000};

    always_comb
    begin
        logic        refresh;
        logic        now_active;
        logic [31:0] merged;
        enable_next = enable_reg;
        pause_next  = pause_reg;
        load_next   = load_reg;
        count_next  = count_reg;
        active_next = active_reg;
        cause_next  = cause_reg;
        tick_next   = tick_reg;
        scr_we      = 1'b0;
        scr_wdata   = alias_apply(scratch_reg[slot_idx], wr_value, kind);
        refresh     = 1'b0;
        now_active  = 1'b0;
        merged      = 32'd0;
        result      = '0;

        case (item.mode)
            MODE_READ:
            begin
                case (item.size_code)
                    SIZE_BYTE: result.read_data = read_shifted & 32'h0000_00ff;
                    SIZE_HALF: result.read_data = read_shifted & 32'h0000_ffff;
                    default:   result.read_data = read_shifted;
                endcase
            end
            MODE_WRITE:
            begin
                if (word == OFF_CTRL)
                begin
                    enable_next = ctrl_new[CTRL_EN_BIT];
                    pause_next  = ctrl_new[26:24];
                    refresh     = 1'b1;
                end
                else if (word == OFF_LOAD)
                begin
                    merged     = alias_apply({8'd0, load_reg}, wr_value, kind);
                    load_next  = merged[23:0] & COUNT_MASK;
                    count_next = load_next;
                    refresh    = 1'b1;
                end
                else if (word == OFF_TICK)
                begin
                    merged    = alias_apply({22'd0, tick_reg}, wr_value, kind);
                    tick_next = merged[9:0];
                    refresh   = 1'b1;
                end
                else if (slot_hit)
                begin
                    scr_we = 1'b1;
                end

                // Activity is recomputed from the updated settings; an active
                // timer that already sits at zero expires in the same item.
                if (refresh)
                begin
                    now_active  = enable_next && tick_next[TICK_EN_BIT]
                                  && (tick_next[8:0] != 9'd0);
                    active_next = now_active;
                    if (now_active && (count_next == 24'd0))
                    begin
                        cause_next           = CAUSE_EXPIRY;
                        active_next          = 1'b0;
                        result.reset_request = 1'b1;
                        result.reset_cause   = CAUSE_EXPIRY;
                    end
                end

                // The trigger bit overrides an expiry in the same write.
                if ((word == OFF_CTRL) && ctrl_new[CTRL_TRIG_BIT])
                begin
                    cause_next           = CAUSE_FORCED;
                    active_next          = 1'b0;
                    result.reset_request = 1'b1;
                    result.reset_cause   = CAUSE_FORCED;
                end
            end
            MODE_TICK:
            begin
                if (active_reg && (count_reg != 24'd0))
                begin
                    count_next = (count_reg > 24'd2) ? (count_reg - 24'd2) : 24'd0;
                    if (count_next == 24'd0)
                    begin
                        cause_next           = CAUSE_EXPIRY;
                        active_next          = 1'b0;
                        result.reset_request = 1'b1;
                        result.reset_cause   = CAUSE_EXPIRY;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pause_reg  <= PAUSE_RESET;
            load_reg   <= 24'd0;
            count_reg  <= 24'd0;
            active_reg <= 1'b0;
            cause_reg  <= CAUSE_NONE;
            tick_reg   <= TICK_RESET;
        end
        else if (fire)
        begin
            enable_reg <= enable_next;
            pause_reg  <= pause_next;
            load_reg   <= load_next;
            count_reg  <= count_next;
            active_reg <= active_next;
            cause_reg  <= cause_next;
            tick_reg   <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCRATCH_WORDS; i++)
            begin
                scratch_reg[i] <= 32'd0;
            end
        end
        else if (fire && scr_we)
        begin
            scratch_reg[slot_idx] <= scr_wdata;
        end
    end

endmodule

FILE: rtl/core/watchdog_register_block.sv
// Watchdog register block.
// The input channel (in_valid / in_ready) carries one beat per bus read, bus
// write or watchdog tick; the output channel (out_valid / out_ready) returns
// exactly one result beat per input beat, in order: read data, and a reset
// request with its cause when the count runs out or the trigger bit is set.
// An accepted beat is held in an input register, executed against the
// register state as it leaves that register, and its result is captured in
// the output register. One beat per cycle is sustained while the receiver
// holds out_ready high.
// When the receiver stalls, the result waits in the output register and the
// next beat waits in the input register; in_ready drops only when both are
// full. Reset (rst_n low) empties both stages and returns the registers to
// their reset values: disabled, pause bits set, count and load zero, tick
// generator enabled with zero cycles, REASON and scratch words zero.
module watchdog_register_block
    import wdt_pkg::*;
#(
    parameter int SCRATCH_WORDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [13:0] address,
    input  logic [31:0] write_data,
    input  logic [1:0]  size_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        reset_request,
    output logic [1:0]  reset_cause
);

    logic        item_valid_reg, item_valid_next;
    wdt_item_t   item_reg, item_next;
    logic        out_valid_reg, out_valid_next;
    wdt_result_t result_reg, result_next;
    wdt_result_t exec_result;
    logic        in_accept;
    logic        advance;

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        item_next = item_reg;
        if (in_accept)
        begin
            item_next.mode       = mode;
            item_next.address    = address;
            item_next.write_data = write_data;
            item_next.size_code  = size_code;
        end
        item_valid_next = in_accept || (item_valid_reg && !advance);
        out_valid_next  = advance || (out_valid_reg && !out_ready);
        result_next     = advance ? exec_result : result_reg;
    end

    wdt_exec #(
        .SCRATCH_WORDS(SCRATCH_WORDS)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (exec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = result_reg.read_data;
    assign reset_request = result_reg.reset_request;
    assign reset_cause   = result_reg.reset_cause;

`ifndef SYNTHESIS
    a_cause_matches_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reset_request == (reset_cause != CAUSE_NONE)))
        else $error("reset_request and reset_cause disagree");

    a_reset_has_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reset_request) |-> (read_data == 32'd0))
        else $error("reset request carries read data");

    a_held_item_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("stalled item lost from input register");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("executed item produced no result beat");
`endif

endmodule

FILE: test/watchdog_register_block_tb.sv
`timescale 1ns / 100ps

import wdt_pkg::*;

// Shadow copy of the watchdog registers. Every accepted input beat is applied
// to the shadow and its reply is queued; every output beat is checked against
// the oldest queued reply.
class wdt_shadow;
    int          slots;
    logic        enable;
    logic [2:0]  pause;
    logic [23:0] load;
    logic [23:0] count;
    logic        active;
    logic [1:0]  reason;
    logic [9:0]  tick_cfg;
    logic [31:0] scratch [8];
    wdt_result_t replies_due [$];
    int unsigned n_reads;
    int unsigned n_writes;
    int unsigned n_ticks;
    int unsigned n_ignored;
    int unsigned n_expiries;
    int unsigned n_forced;
    int unsigned n_checked;
    int unsigned mismatches;

    function new(int n);
        slots    = n;
        enable   = 1'b0;
        pause    = PAUSE_RESET;
        load     = '0;
        count    = '0;
        active   = 1'b0;
        reason   = CAUSE_NONE;
        tick_cfg = TICK_RESET;
        foreach (scratch[i])
        begin
            scratch[i] = '0;
        end
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

    function logic [31:0] merge(logic [31:0] old_v, logic [31:0] v, logic [1:0] kind);
        logic [31:0] res;
        res = v;
        if (kind == ALIAS_XOR)
        begin
            res = old_v ^ v;
        end
        else if (kind == ALIAS_SET)
        begin
            res = old_v | v;
        end
        else if (kind == ALIAS_CLR)
        begin
            res = old_v & ~v;
        end
        return res;
    endfunction

    function logic tick_running();
        return tick_cfg[TICK_EN_BIT] && (tick_cfg[8:0] != 9'd0);
    endfunction

    function logic [31:0] ctrl_word();
        return {1'b0, enable, 3'b000, pause, count};
    endfunction

    function logic [31:0] tick_word();
        logic [31:0] w;
        w = {22'b0, tick_cfg};
        if (tick_running())
        begin
            w = w | 32'h0000_0400 | ({23'b0, tick_cfg[8:0]} << 11);
        end
        return w;
    endfunction

    function int slot_of(logic [11:0] word);
        int idx;
        idx = int'(word[11:2]) - int'(SCRATCH_BASE_WORD);
        if (idx >= 0 && idx < slots && idx < 8)
        begin
            return idx;
        end
        return -1;
    endfunction

    // Recompute whether the timer runs; a zero count expires on the spot.
    function logic rearm();
        active = enable && tick_running();
        if (active && count == 24'd0)
        begin
            reason = CAUSE_EXPIRY;
            active = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void note_beat(logic [1:0] op, logic [13:0] addr, logic [31:0] wdata,
                            logic [1:0] sz);
        logic [1:0]  kind;
        logic [11:0] offs;
        logic [11:0] word;
        logic [31:0] v;
        logic [31:0] nv;
        wdt_result_t reply;
        int          slot;
        kind  = addr[13:12];
        offs  = addr[11:0];
        word  = {offs[11:2], 2'b00};
        slot  = slot_of(word);
        reply = '0;
        reply.reset_cause = CAUSE_NONE;
        if (op == MODE_READ)
        begin
            n_reads++;
            v = '0;
            if (word == OFF_CTRL)
            begin
                v = ctrl_word();
            end
            else if (word == OFF_REASON)
            begin
                v = {30'b0, reason};
            end
            else if (word == OFF_TICK)
            begin
                v = tick_word();
            end
            else if (slot >= 0)
            begin
                v = scratch[slot];
            end
            v = v >> {offs[1:0], 3'b000};
            if (sz == SIZE_BYTE)
            begin
                v = v & 32'h0000_00ff;
            end
            else if (sz == SIZE_HALF)
            begin
                v = v & 32'h0000_ffff;
            end
            reply.read_data = v;
        end
        else if (op == MODE_WRITE)
        begin
            n_writes++;
            // Narrow writes replicate their lanes across the word.
            if (sz == SIZE_BYTE)
            begin
                v = {4{wdata[7:0]}};
            end
            else if (sz == SIZE_HALF)
            begin
                v = {2{wdata[15:0]}};
            end
            else
            begin
                v = wdata;
            end
            if (word == OFF_CTRL)
            begin
                nv     = merge(ctrl_word(), v, kind);
                enable = nv[CTRL_EN_BIT];
                pause  = nv[26:24];
                if (rearm())
                begin
                    reply.reset_request = 1'b1;
                    reply.reset_cause   = CAUSE_EXPIRY;
                end
                // The trigger wins over an expiry in the same beat.
                if (nv[CTRL_TRIG_BIT])
                begin
                    reason              = CAUSE_FORCED;
                    active              = 1'b0;
                    reply.reset_request = 1'b1;
                    reply.reset_cause   = CAUSE_FORCED;
                end
            end
            else if (word == OFF_LOAD)
            begin
                nv    = merge({8'b0, load}, v, kind);
                load  = nv[23:0];
                count = load;
                if (rearm())
                begin
                    reply.reset_request = 1'b1;
                    reply.reset_cause   = CAUSE_EXPIRY;
                end
            end
            else if (word == OFF_TICK)
            begin
                nv       = merge({22'b0, tick_cfg}, v, kind);
                tick_cfg = nv[9:0];
                if (rearm())
                begin
                    reply.reset_request = 1'b1;
                    reply.reset_cause   = CAUSE_EXPIRY;
                end
            end
            else if (slot >= 0)
            begin
                scratch[slot] = merge(scratch[slot], v, kind);
            end
        end
        else if (op == MODE_TICK)
        begin
            n_ticks++;
            if (active && count != 24'd0)
            begin
                count = (count > 24'd2) ? count - 24'd2 : 24'd0;
                if (count == 24'd0)
                begin
                    reason              = CAUSE_EXPIRY;
                    active              = 1'b0;
                    reply.reset_request = 1'b1;
                    reply.reset_cause   = CAUSE_EXPIRY;
                end
            end
        end
        else
        begin
            n_ignored++;
        end
        if (reply.reset_cause == CAUSE_EXPIRY)
        begin
            n_expiries++;
        end
        else if (reply.reset_cause == CAUSE_FORCED)
        begin
            n_forced++;
        end
        replies_due.push_back(reply);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_reply(logic [31:0] rd, logic req, logic [1:0] why);
        wdt_result_t want;
        if (replies_due.size() == 0)
        begin
            report_mismatch($sformatf("reply beat %08h/%0b/%0d with nothing outstanding",
                                      rd, req, why));
            return;
        end
        want = replies_due.pop_front();
        n_checked++;
        if (rd !== want.read_data)
        begin
            report_mismatch($sformatf("beat %0d read_data %08h, predicted %08h",
                                      n_checked, rd, want.read_data));
        end
        if (req !== want.reset_request)
        begin
            report_mismatch($sformatf("beat %0d reset_request %0b, predicted %0b",
                                      n_checked, req, want.reset_request));
        end
        if (why !== want.reset_cause)
        begin
            report_mismatch($sformatf("beat %0d reset_cause %0d, predicted %0d",
                                      n_checked, why, want.reset_cause));
        end
    endtask
endclass

module watchdog_register_block_tb;
    import wdt_pkg::*;

    localparam int          SCRATCH_COUNT = 8;
    localparam int          ITEM_TARGET   = 850;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [1:0]  MODE_NONE     = 2'd3;
    localparam logic [1:0]  SIZE_WORD     = 2'd2;
    localparam logic [1:0]  SIZE_RSVD     = 2'd3;
    localparam logic [11:0] OFF_SCRATCH0  = 12'h00c;
    localparam logic [11:0] OFF_SCRATCH7  = 12'h028;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [13:0] address;
    logic [31:0] write_data;
    logic [1:0]  size_code;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        reset_request;
    logic [1:0]  reset_cause;

    wdt_shadow   shadow;
    int          sent_items;
    int          beats_in = 0;
    int          cycles;
    bit          sender_calm;

    watchdog_register_block #(
        .SCRATCH_WORDS(SCRATCH_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .address      (address),
        .write_data   (write_data),
        .size_code    (size_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .reset_request(reset_request),
        .reset_cause  (reset_cause)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                shadow.note_beat(mode, address, write_data, size_code);
                beats_in <= beats_in + 1;
            end
            if (out_valid && out_ready)
            begin
                shadow.check_reply(read_data, reset_request, reset_cause);
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off that
    // fills both pipeline stages and pushes back on the sender.
    initial
    begin
        int quiet;
        int calm;
        int r;
        bit long_done;
        quiet     = 0;
        calm      = 0;
        long_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!long_done && beats_in >= 400)
            begin
                long_done = 1'b1;
                quiet     = 150;
            end
            if (quiet > 0)
            begin
                out_ready <= 1'b0;
                quiet--;
            end
            else if (calm > 0)
            begin
                out_ready <= 1'b1;
                calm--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    calm = $urandom_range(30, 120);
                end
                if (r < 70)
                begin
                    out_ready <= 1'b1;
                end
                else if (r < 95)
                begin
                    out_ready <= 1'b0;
                    quiet = $urandom_range(0, 3);
                end
                else
                begin
                    out_ready <= 1'b0;
                    quiet = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Watchdog test ran out of time after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
    end

    task automatic offer_beat(input logic [1:0] op, input logic [13:0] addr,
                              input logic [31:0] data, input logic [1:0] sz);
        int gap;
        int r;
        in_valid   <= 1'b1;
        mode       <= op;
        address    <= addr;
        write_data <= data;
        size_code  <= sz;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (op != MODE_NONE)
        begin
            sent_items++;
        end
        r = $urandom_range(0, 99);
        if (sender_calm || r < 60)
        begin
            gap = 0;
        end
        else if (r < 90)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            gap = $urandom_range(4, 10);
        end
        else
        begin
            gap = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [1:0] random_kind();
        return ($urandom_range(0, 3) == 0) ? 2'($urandom) : ALIAS_PLAIN;
    endfunction

    function automatic logic [1:0] random_size();
        return ($urandom_range(0, 9) < 7) ? SIZE_WORD : 2'($urandom_range(0, 3));
    endfunction

    function automatic logic [11:0] random_offset();
        int r;
        logic [11:0] w;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            w = OFF_CTRL;
        end
        else if (r == 1)
        begin
            w = OFF_LOAD;
        end
        else if (r == 2)
        begin
            w = OFF_REASON;
        end
        else if (r <= 10)
        begin
            w = OFF_SCRATCH0 + 12'(4 * (r - 3));
        end
        else if (r == 11)
        begin
            w = OFF_TICK;
        end
        else
        begin
            w = 12'($urandom);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            w[1:0] = 2'($urandom);
        end
        return w;
    endfunction

    task automatic run_directed();
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_CTRL}, 32'h0, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_TICK}, 32'h0, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_CLR, OFF_REASON}, 32'hffff_ffff, SIZE_WORD);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_TICK}, 32'h0000_0205, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_TICK}, 32'h0, SIZE_WORD);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_LOAD}, 32'hffff_ffff, SIZE_WORD);
        // LOAD is write only.
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_LOAD}, 32'h0, SIZE_WORD);
        offer_beat(MODE_WRITE, {ALIAS_SET, OFF_CTRL}, 32'h4000_0000, SIZE_WORD);
        offer_beat(MODE_TICK, 14'h0, 32'h0, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_XOR, OFF_CTRL | 12'h001}, 32'h0, SIZE_BYTE);
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_CTRL | 12'h003}, 32'h0, SIZE_HALF);
        // An odd count reaches zero in the second tick.
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_LOAD}, 32'h0000_0003, SIZE_WORD);
        offer_beat(MODE_TICK, 14'h3fff, 32'hffff_ffff, SIZE_BYTE);
        offer_beat(MODE_TICK, 14'h0, 32'h0, SIZE_WORD);
        offer_beat(MODE_TICK, 14'h0, 32'h0, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_REASON}, 32'h0, SIZE_WORD);
        // Loading zero while armed expires at once.
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_LOAD}, 32'h0, SIZE_WORD);
        // The byte replicates into the trigger bit, which beats the expiry.
        offer_beat(MODE_WRITE, {ALIAS_XOR, OFF_CTRL}, 32'h0000_0080, SIZE_BYTE);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_SCRATCH0}, 32'h00be_ef12, SIZE_HALF);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_SCRATCH7}, 32'ha5a5_a5a5, SIZE_WORD);
        offer_beat(MODE_WRITE, {ALIAS_CLR, OFF_SCRATCH7}, 32'h0000_ffff, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_SCRATCH7 | 12'h002}, 32'h0, SIZE_RSVD);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_REASON}, 32'hffff_ffff, SIZE_WORD);
        offer_beat(MODE_READ, {ALIAS_SET, 12'hffc}, 32'h0, SIZE_WORD);
        offer_beat(MODE_NONE, 14'h3fff, 32'hffff_ffff, SIZE_RSVD);
        offer_beat(MODE_WRITE, {ALIAS_CLR, OFF_TICK}, 32'h0000_0200, SIZE_WORD);
    endtask

    // Arm the watchdog with a short count, then mostly tick it down with
    // reads, scratch traffic and the odd LOAD or CTRL write mixed in.
    task automatic run_countdown_sequence();
        int steps;
        int r;
        logic [8:0]  cyc;
        logic [31:0] d;
        sender_calm = ($urandom_range(0, 4) == 0);
        cyc = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(1, 511))
                                          : 9'($urandom_range(1, 4));
        if ($urandom_range(0, 19) == 0)
        begin
            cyc = 9'd0;
        end
        d      = $urandom;
        d[9]   = ($urandom_range(0, 9) != 0);
        d[8:0] = cyc;
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_TICK}, d, SIZE_WORD);
        d = $urandom;
        if ($urandom_range(0, 7) != 0)
        begin
            d[23:0] = 24'($urandom_range(0, 40));
        end
        offer_beat(MODE_WRITE, {random_kind(), OFF_LOAD}, d, SIZE_WORD);
        d     = $urandom;
        d[31] = ($urandom_range(0, 11) == 0);
        d[30] = ($urandom_range(0, 9) != 0);
        offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_CTRL}, d, SIZE_WORD);
        steps = $urandom_range(4, 30);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                offer_beat(MODE_TICK, 14'($urandom), $urandom, 2'($urandom));
            end
            else if (r < 72)
            begin
                offer_beat(MODE_READ, {random_kind(), random_offset()}, $urandom,
                           random_size());
            end
            else if (r < 82)
            begin
                offer_beat(MODE_READ, {ALIAS_PLAIN, OFF_CTRL}, $urandom, SIZE_WORD);
            end
            else if (r < 92)
            begin
                offer_beat(MODE_WRITE,
                           {random_kind(), OFF_SCRATCH0 + 12'(4 * $urandom_range(0, 7))},
                           $urandom, random_size());
            end
            else if (r < 97)
            begin
                offer_beat(MODE_WRITE, {ALIAS_PLAIN, OFF_LOAD},
                           32'($urandom_range(0, 40)), SIZE_WORD);
            end
            else
            begin
                offer_beat(MODE_WRITE, {random_kind(), OFF_CTRL}, $urandom, random_size());
            end
        end
        sender_calm = 1'b0;
    endtask

    initial
    begin
        int  random_start;
        bit  paused_once;
        shadow      = new(SCRATCH_COUNT);
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_READ;
        address     = '0;
        write_data  = '0;
        size_code   = SIZE_WORD;
        sent_items  = 0;
        sender_calm = 1'b0;
        paused_once = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        random_start = sent_items;
        while (sent_items - random_start < ITEM_TARGET)
        begin
            // Let the pipeline run dry once in the middle of the random part.
            if (!paused_once && sent_items - random_start >= 550)
            begin
                wait_drained();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    offer_beat(2'($urandom), 14'($urandom), $urandom, 2'($urandom));
                end
            end
            else
            begin
                run_countdown_sequence();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Covered %0d reads, %0d writes, %0d ticks and %0d ignored beats",
                 shadow.n_reads, shadow.n_writes, shadow.n_ticks, shadow.n_ignored);
        $display("%0d timer expiries and %0d forced resets predicted, %0d replies checked",
                 shadow.n_expiries, shadow.n_forced, shadow.n_checked);
        if (shadow.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: watchdog_register_block.f
rtl/core/wdt_pkg.sv
rtl/core/wdt_exec.sv
rtl/core/watchdog_register_block.sv
test/watchdog_register_block_tb.sv
